### rtl/core/dctb_pkg.sv
// Shared types, codes and constants for the drift-compensated timer bank.
package dctb_pkg;

    localparam int TIMER_COUNT_DEF = 16;
    localparam int TIME_W          = 24;
    localparam int ELAPSED_W       = 16;
    localparam int MASK_W          = 16;
    localparam int IDX_W           = 4;
    localparam int REQ_W           = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_ONCE  = 2'd1,
        REQ_EVERY = 2'd2,
        REQ_STOP  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMD  = 4'b0010,
        ST_WALK = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic cmd_write;
        logic walk_run;
        logic push;
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_tick;
        logic walk_done;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/core/dctb_ctrl.sv
// Controller state machine for the timer bank: sequences accept, update, walk and result.
module dctb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dctb_pkg::dp_stat_t  stat,
    output dctb_pkg::ctl_cmd_t  cmd
);

    dctb_pkg::state_t state_reg;
    dctb_pkg::state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dctb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            dctb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_tick ? dctb_pkg::ST_WALK : dctb_pkg::ST_CMD;
                end
            end
            dctb_pkg::ST_CMD:
            begin
                cmd.cmd_write = 1'b1;
                state_next    = dctb_pkg::ST_FIN;
            end
            dctb_pkg::ST_WALK:
            begin
                cmd.walk_run = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = dctb_pkg::ST_FIN;
                end
            end
            dctb_pkg::ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = dctb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dctb_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != dctb_pkg::ST_IDLE);

    // Hold off new transactions until the current one is finished
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted again right after a transaction");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> stat.out_free)
        else $error("result pushed into an occupied output register");

    a_walk_leaves_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_run && stat.walk_done |=> state_reg == dctb_pkg::ST_FIN)
        else $error("walk finished without moving to result stage");

endmodule

### rtl/core/dctb_dp.sv
// Datapath for the timer bank: item registers, timer memory, countdown walk and result register.
module dctb_dp #(
    parameter int TIMER_COUNT = dctb_pkg::TIMER_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [dctb_pkg::REQ_W-1:0]          req_type,
    input  logic [dctb_pkg::IDX_W-1:0]          timer_index,
    input  logic [dctb_pkg::TIME_W-1:0]         interval_ms,
    input  logic [dctb_pkg::ELAPSED_W-1:0]      elapsed_ms,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [dctb_pkg::MASK_W-1:0]         fired_mask,
    input  dctb_pkg::ctl_cmd_t                  cmd,
    output dctb_pkg::dp_stat_t                  stat
);

    localparam int ADDR_W     = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int WALK_COUNT = (TIMER_COUNT < dctb_pkg::MASK_W) ? TIMER_COUNT
                                                                 : dctb_pkg::MASK_W;
    localparam int CNT_W      = $clog2(WALK_COUNT + 1);

    localparam int TW = dctb_pkg::TIME_W;

    // Item registers
    logic [dctb_pkg::REQ_W-1:0]     req_reg;
    logic [dctb_pkg::IDX_W-1:0]     idx_reg;
    logic [TW-1:0]                  interval_reg;
    logic [dctb_pkg::ELAPSED_W-1:0] elapsed_reg;

    // Timer storage
    logic [TW-1:0]          rem_mem [TIMER_COUNT];
    logic [TW-1:0]          rel_mem [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] valid_reg;
    logic [TIMER_COUNT-1:0] valid_next;

    // Walk control
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              pend_reg;
    logic              pend_next;
    logic [ADDR_W-1:0] wb_addr_reg;
    logic [ADDR_W-1:0] wb_addr_next;
    logic [TW-1:0]     rem_rd_reg;
    logic [TW-1:0]     rel_rd_reg;
    logic              vld_rd_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Result
    logic [dctb_pkg::MASK_W-1:0] mask_reg;
    logic [dctb_pkg::MASK_W-1:0] mask_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [dctb_pkg::MASK_W-1:0] fired_mask_reg;
    logic [dctb_pkg::MASK_W-1:0] fired_mask_next;

    // Countdown and write port
    logic [TW-1:0]     elapsed_ext;
    logic [TW-1:0]     rem_eff;
    logic [TW-1:0]     rel_eff;
    logic [TW-1:0]     over;
    logic [TW-1:0]     rem_new;
    logic              fire;
    logic              wb_en;
    logic              idx_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [TW-1:0]     wr_rem;
    logic [TW-1:0]     wr_rel;

    // Latch the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg      <= req_type;
            idx_reg      <= timer_index;
            interval_reg <= interval_ms;
            elapsed_reg  <= elapsed_ms;
        end
    end

    // Step the walk: issue one read per cycle, write back the previous entry
    always_comb
    begin
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        wb_addr_next = wb_addr_reg;
        rd_en        = 1'b0;
        rd_addr      = ADDR_W'(cnt_reg);
        if (cmd.load)
        begin
            cnt_next  = '0;
            pend_next = 1'b0;
        end
        else if (cmd.walk_run)
        begin
            if (cnt_reg != CNT_W'(WALK_COUNT))
            begin
                rd_en        = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                pend_next    = 1'b1;
                wb_addr_next = rd_addr;
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
    end

    // Count down one timer and compute its reload
    always_comb
    begin
        elapsed_ext = TW'(elapsed_reg);
        rem_eff     = vld_rd_reg ? rem_rd_reg : '0;
        rel_eff     = vld_rd_reg ? rel_rd_reg : '0;
        over        = elapsed_ext - rem_eff;
        fire        = 1'b0;
        if (rem_eff > elapsed_ext)
        begin
            rem_new = rem_eff - elapsed_ext;
        end
        else
        begin
            fire = (rem_eff != '0);
            priority if (rel_eff > over)
            begin
                rem_new = rel_eff - over;
            end
            else if (rel_eff != '0)
            begin
                rem_new = TW'(1);
            end
            else
            begin
                rem_new = '0;
            end
        end
    end

    assign wb_en  = cmd.walk_run && pend_reg && (rem_eff != '0);
    assign idx_ok = (32'(idx_reg) < TIMER_COUNT);

    // Select the write port source: command update or walk write-back
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wb_addr_reg;
        wr_rem  = rem_new;
        wr_rel  = rel_eff;
        if (cmd.cmd_write)
        begin
            wr_en   = idx_ok;
            wr_addr = ADDR_W'(idx_reg);
            unique case (dctb_pkg::req_t'(req_reg))
                dctb_pkg::REQ_ONCE:
                begin
                    wr_rem = interval_reg;
                    wr_rel = '0;
                end
                dctb_pkg::REQ_EVERY:
                begin
                    wr_rem = interval_reg;
                    wr_rel = interval_reg;
                end
                dctb_pkg::REQ_STOP,
                dctb_pkg::REQ_TICK:
                begin
                    wr_rem = '0;
                    wr_rel = '0;
                end
            endcase
        end
        else if (wb_en)
        begin
            wr_en = 1'b1;
        end
    end

    // Timer memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rem_mem[wr_addr] <= wr_rem;
            rel_mem[wr_addr] <= wr_rel;
        end
        if (rd_en)
        begin
            rem_rd_reg <= rem_mem[rd_addr];
            rel_rd_reg <= rel_mem[rd_addr];
        end
    end

    // Mark entries written since reset; unwritten entries read as stopped
    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    // Collect fired timers; clear on every new transaction
    always_comb
    begin
        mask_next = mask_reg;
        if (cmd.load)
        begin
            mask_next = '0;
        end
        else if (cmd.walk_run && pend_reg && fire)
        begin
            mask_next = mask_reg | (dctb_pkg::MASK_W'(1) << wb_addr_reg);
        end
    end

    // Output register: load on push, drop when taken
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        fired_mask_next = fired_mask_reg;
        if (cmd.push)
        begin
            out_valid_next  = 1'b1;
            fired_mask_next = mask_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            vld_rd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (rd_en)
            begin
                vld_rd_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg    <= wb_addr_next;
        mask_reg       <= mask_next;
        fired_mask_reg <= fired_mask_next;
    end

    assign out_valid      = out_valid_reg;
    assign fired_mask     = fired_mask_reg;
    assign stat.in_tick   = (dctb_pkg::req_t'(req_type) == dctb_pkg::REQ_TICK);
    assign stat.walk_done = (cnt_reg == CNT_W'(WALK_COUNT)) && !pend_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // A command transaction never reports a fired timer
    a_cmd_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push && (dctb_pkg::req_t'(req_reg) != dctb_pkg::REQ_TICK) |-> mask_reg == '0)
        else $error("command transaction carries a nonzero fired mask");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.cmd_write && cmd.walk_run))
        else $error("command update and walk write-back in the same cycle");

    a_wb_in_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (32'(wb_addr_reg) < WALK_COUNT))
        else $error("walk write-back beyond the addressable timers");

endmodule

### rtl/core/drift_compensated_timer_bank.sv
// Top level of the drift-compensated millisecond timer bank.
// Tick transaction: the walk reads one timer per cycle through the single read port of the
// timer memory, then the fired mask is pushed into the output register.
// Arm or stop transaction: the entry is written in the command state, then an empty mask is pushed.
// One transaction at a time: in_stall holds off a new request until the current result is pushed.
// Reset (rst_n, asynchronous, active low) stops all timers via per-entry valid bits.
module drift_compensated_timer_bank #(
    parameter int TIMER_COUNT = dctb_pkg::TIMER_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dctb_pkg::REQ_W-1:0]      req_type,
    input  logic [dctb_pkg::IDX_W-1:0]      timer_index,
    input  logic [dctb_pkg::TIME_W-1:0]     interval_ms,
    input  logic [dctb_pkg::ELAPSED_W-1:0]  elapsed_ms,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dctb_pkg::MASK_W-1:0]     fired_mask
);

    dctb_pkg::ctl_cmd_t cmd;
    dctb_pkg::dp_stat_t stat;

    // Sequence each transaction
    dctb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold timers and compute countdowns
    dctb_dp #(
        .TIMER_COUNT (TIMER_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req_type),
        .timer_index (timer_index),
        .interval_ms (interval_ms),
        .elapsed_ms  (elapsed_ms),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .fired_mask  (fired_mask),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

### tb/testbench.sv
// Self-checking testbench for the drift-compensated millisecond timer bank.
`timescale 1ns / 100ps

module testbench;

    localparam int NUM_TIMERS   = dctb_pkg::TIMER_COUNT_DEF;
    localparam int RANDOM_ITEMS = 430;
    localparam int REQ_W        = dctb_pkg::REQ_W;
    localparam int IDX_W        = dctb_pkg::IDX_W;
    localparam int TIME_W       = dctb_pkg::TIME_W;
    localparam int ELAPSED_W    = dctb_pkg::ELAPSED_W;
    localparam int MASK_W       = dctb_pkg::MASK_W;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [REQ_W-1:0]     req_type;
    logic [IDX_W-1:0]     timer_index;
    logic [TIME_W-1:0]    interval_ms;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 out_valid;
    logic                 out_stall;
    logic [MASK_W-1:0]    fired_mask;

    // Model state of the bank: time left and periodic interval per timer
    logic [TIME_W-1:0]    time_left [NUM_TIMERS];
    logic [TIME_W-1:0]    period    [NUM_TIMERS];
    logic [MASK_W-1:0]    expected_fired [$];

    int                   mismatch_count;
    int                   gap_pct;
    int                   stall_pct;

    drift_compensated_timer_bank u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .timer_index (timer_index),
        .interval_ms (interval_ms),
        .elapsed_ms  (elapsed_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fired_mask  (fired_mask)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // End the run if it hangs
    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Apply one request to the model bank and return the timers that fire
    function automatic logic [MASK_W-1:0] update_timer_bank(input dctb_pkg::req_t req,
                                                             input logic [IDX_W-1:0] idx,
                                                             input logic [TIME_W-1:0] ival,
                                                             input logic [ELAPSED_W-1:0] el);
        logic [MASK_W-1:0] mask;
        int unsigned       left;
        int unsigned       over;
        int unsigned       el_ext;
        mask   = '0;
        el_ext = 32'(el);
        if (req == dctb_pkg::REQ_TICK)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                left = 32'(time_left[i]);
                if (left > el_ext)
                    time_left[i] = TIME_W'(left - el_ext);
                else if (left != 0)
                begin
                    // Reload less the overshoot; a late periodic timer gets one ms
                    over = el_ext - left;
                    if (32'(period[i]) > over)
                        time_left[i] = TIME_W'(32'(period[i]) - over);
                    else if (period[i] != '0)
                        time_left[i] = TIME_W'(1);
                    else
                        time_left[i] = '0;
                    if (i < MASK_W)
                        mask[i] = 1'b1;
                end
            end
        end
        else if (idx < NUM_TIMERS)
        begin
            case (req)
                dctb_pkg::REQ_ONCE:
                begin
                    time_left[idx] = ival;
                    period[idx]    = '0;
                end
                dctb_pkg::REQ_EVERY:
                begin
                    time_left[idx] = ival;
                    period[idx]    = ival;
                end
                default:
                begin
                    time_left[idx] = '0;
                    period[idx]    = '0;
                end
            endcase
        end
        return mask;
    endfunction

    // Drive one request transaction and record its expected mask on accept
    task automatic send_request(input dctb_pkg::req_t req, input logic [IDX_W-1:0] idx,
                                input logic [TIME_W-1:0] ival,
                                input logic [ELAPSED_W-1:0] el);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        req_type    <= req;
        timer_index <= idx;
        interval_ms <= ival;
        elapsed_ms  <= el;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_fired.push_back(update_timer_bank(req, idx, ival, el));
    endtask

    // Drop valid after the last transaction
    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait until every expected mask has come back
    task automatic wait_results();
        while (expected_fired.size() != 0)
            @(posedge clk);
    endtask

    // Stall the result channel at random
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Check each result transaction against the oldest expectation
    initial
    begin
        logic [MASK_W-1:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_fired.size() == 0)
                begin
                    $error("fired_mask: expected none, actual %h", fired_mask);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_fired.pop_front();
                    if (fired_mask !== want)
                    begin
                        $error("fired_mask: expected %h, actual %h", want, fired_mask);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Arm, stop and re-arm commands with extreme intervals
    task automatic test_commands();
        send_request(dctb_pkg::REQ_ONCE, 4'd0, 24'd1, 16'hFFFF);
        send_request(dctb_pkg::REQ_EVERY, 4'd15, 24'hFFFFFF, 16'd0);
        send_request(dctb_pkg::REQ_ONCE, 4'd5, 24'd0, 16'd0);
        send_request(dctb_pkg::REQ_EVERY, 4'd6, 24'd0, 16'd0);
        send_request(dctb_pkg::REQ_ONCE, 4'd7, 24'd100, 16'd0);
        send_request(dctb_pkg::REQ_EVERY, 4'd7, 24'd4, 16'd0);
        send_request(dctb_pkg::REQ_ONCE, 4'd8, 24'd50, 16'd0);
        send_request(dctb_pkg::REQ_STOP, 4'd8, 24'hFFFFFF, 16'hFFFF);
        send_request(dctb_pkg::REQ_EVERY, 4'd3, 24'd10, 16'd0);
        send_request(dctb_pkg::REQ_ONCE, 4'd10, 24'd5, 16'd0);
        send_request(dctb_pkg::REQ_EVERY, 4'd12, 24'd9, 16'd0);
    endtask

    // Ticks: zero elapsed, exact expiry, small and large overshoot
    task automatic test_ticks();
        send_request(dctb_pkg::REQ_TICK, 4'hF, 24'hFFFFFF, 16'd0);
        send_request(dctb_pkg::REQ_TICK, 4'd0, 24'd0, 16'd1);
        send_request(dctb_pkg::REQ_TICK, 4'd0, 24'd0, 16'd4);
        send_request(dctb_pkg::REQ_TICK, 4'd0, 24'd0, 16'd6);
        send_request(dctb_pkg::REQ_TICK, 4'd0, 24'd0, 16'd25);
        send_request(dctb_pkg::REQ_TICK, 4'd0, 24'd0, 16'd1);
        send_request(dctb_pkg::REQ_TICK, 4'd0, 24'd0, 16'hFFFF);
        send_request(dctb_pkg::REQ_STOP, 4'd15, 24'd0, 16'd0);
        send_request(dctb_pkg::REQ_TICK, 4'd0, 24'd0, 16'd2);
        send_request(dctb_pkg::REQ_TICK, 4'd0, 24'd0, 16'd0);
    endtask

    // Random traffic biased toward short intervals so timers fire often
    task automatic test_random(input int count);
        dctb_pkg::req_t       req;
        logic [TIME_W-1:0]    ival;
        logic [ELAPSED_W-1:0] el;
        int                   pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                req = dctb_pkg::REQ_TICK;
            else if (pick < 67)
                req = dctb_pkg::REQ_ONCE;
            else if (pick < 88)
                req = dctb_pkg::REQ_EVERY;
            else
                req = dctb_pkg::REQ_STOP;

            pick = $urandom_range(99);
            if (pick < 5)
                ival = '0;
            else if (pick < 15)
                ival = TIME_W'($urandom);
            else if (pick < 18)
                ival = '1;
            else
                ival = TIME_W'($urandom_range(60, 1));

            pick = $urandom_range(99);
            if (pick < 8)
                el = '0;
            else if (pick < 13)
                el = ELAPSED_W'($urandom);
            else if (pick < 15)
                el = '1;
            else
                el = ELAPSED_W'($urandom_range(30, 1));

            send_request(req, IDX_W'($urandom_range(NUM_TIMERS - 1)), ival, el);
        end
        stop_sending();
        wait_results();
    endtask

    // Reset, then run the tests in turn
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        req_type       = dctb_pkg::REQ_TICK;
        timer_index    = '0;
        interval_ms    = '0;
        elapsed_ms     = '0;
        mismatch_count = 0;
        gap_pct        = 9;
        stall_pct      = 64;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            time_left[i] = '0;
            period[i]    = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_commands();
        test_ticks();
        stop_sending();
        wait_results();

        test_random(RANDOM_ITEMS);
        gap_pct   = 64;
        stall_pct = 9;
        test_random(RANDOM_ITEMS);
        gap_pct   = 0;
        stall_pct = 0;
        test_random(RANDOM_ITEMS);

        // Let any stray result show up
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_fired.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
